// ===== hw/rtl/psl_pkg.sv =====
package psl_pkg;

	localparam int CAL_POINTS  = 11;
	localparam int TEMP_POINTS = 4;
	localparam int SEG_W  = $clog2(CAL_POINTS);
	localparam int TSEG_W = $clog2(TEMP_POINTS);

	// divider: numerator magnitude plus rounding term, denominator
	localparam int DIV_NW = 58;
	localparam int DIV_DW = 32;

	localparam logic signed [31:0] ADC_PTS [CAL_POINTS] = '{
		32'sd98717, 32'sd594404, 32'sd1089976, 32'sd1585548, 32'sd2080942,
		32'sd2576264, 32'sd3071423, 32'sd3566551, 32'sd4061479, 32'sd4556289,
		32'sd5051115};
	localparam logic signed [31:0] SUP_PTS [CAL_POINTS] = '{
		32'sd3381422, 32'sd3381431, 32'sd3381501, 32'sd3381593, 32'sd3381896,
		32'sd3382039, 32'sd3382234, 32'sd3382476, 32'sd3382791, 32'sd3383102,
		32'sd3383419};
	// k * 0.7 in Q8.24
	localparam logic signed [31:0] PRS_PTS [CAL_POINTS] = '{
		32'sd0, 32'sd11744051, 32'sd23488102, 32'sd35232154, 32'sd46976205,
		32'sd58720256, 32'sd70464307, 32'sd82208358, 32'sd93952410,
		32'sd105696461, 32'sd117440512};
	// Q2.30
	localparam logic signed [31:0] COEF_PTS [TEMP_POINTS] = '{
		32'sd1067580693, 32'sd1080149915, 32'sd1090277448, 32'sd1181116006};
	// 1/256 degree
	localparam logic signed [31:0] TMP_PTS [TEMP_POINTS] = '{
		32'sd3840, 32'sd5453, 32'sd6290, 32'sd7680};

	localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
	localparam logic [1:0] REG_REF_TEMP    = 2'd1;
	localparam logic [1:0] REG_DRIFT_GAIN  = 2'd2;

	localparam logic signed [15:0] REF_TEMP_RESET = 16'sd3840;

	// datapath operations
	localparam logic [4:0] OP_NONE = 5'd0;
	localparam logic [4:0] OP_LOAD = 5'd1;
	localparam logic [4:0] OP_SEG  = 5'd2;
	localparam logic [4:0] OP_MULP = 5'd3;
	localparam logic [4:0] OP_DIVP = 5'd4;
	localparam logic [4:0] OP_GETP = 5'd5;
	localparam logic [4:0] OP_MULR = 5'd6;
	localparam logic [4:0] OP_SUMR = 5'd7;
	localparam logic [4:0] OP_DIVR = 5'd8;
	localparam logic [4:0] OP_GETR = 5'd9;
	localparam logic [4:0] OP_DIVC = 5'd10;
	localparam logic [4:0] OP_GETC = 5'd11;
	localparam logic [4:0] OP_SEGT = 5'd12;
	localparam logic [4:0] OP_DIVT = 5'd13;
	localparam logic [4:0] OP_GETT = 5'd14;
	localparam logic [4:0] OP_MULG = 5'd15;
	localparam logic [4:0] OP_CORR = 5'd16;
	localparam logic [4:0] OP_OUT  = 5'd17;

	typedef struct packed {
		logic [4:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/psl_div.sv =====
// rounded signed division, one quotient bit per cycle
module psl_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [psl_pkg::DIV_NW-1:0] num,
	input  logic        [psl_pkg::DIV_DW-1:0] den,
	output logic                             done,
	output logic signed [psl_pkg::DIV_NW:0]   quo
);
	localparam int NW = psl_pkg::DIV_NW;
	localparam int DW = psl_pkg::DIV_DW;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q, neg_q;

	logic [NW-1:0] mag;
	logic [DW:0]   rem_sh, rem_sub;

	always_comb begin
		mag     = num[NW-1] ? NW'(-num) : NW'(num);
		mag     = mag + NW'(den[DW-1:1]);
		rem_sh  = {rem_q, n_q[NW-1]};
		rem_sub = rem_sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= mag;
			d_q   <= den;
			rem_q <= '0;
			neg_q <= num[NW-1];
		end else if (busy_q) begin
			if (!rem_sub[DW]) begin
				rem_q <= rem_sub[DW-1:0];
				n_q   <= {n_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				n_q   <= {n_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});

endmodule

// ===== hw/rtl/psl_dp.sv =====
module psl_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psl_pkg::dp_cmd_t      cmd,
	output psl_pkg::dp_stat_t     stat,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic [47:0]           s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [87:0]           m_tdata,
	output logic                  m_tuser
);
	localparam int SW = psl_pkg::SEG_W;
	localparam int TW = psl_pkg::TSEG_W;
	localparam int NW = psl_pkg::DIV_NW;
	localparam int DW = psl_pkg::DIV_DW;

	logic signed [23:0] zo_q;
	logic signed [15:0] rt_q;
	logic signed [31:0] gain_q;
	logic signed [31:0] prev_q;

	logic signed [25:0] x_q;
	logic signed [23:0] sup_q;
	logic [SW-1:0]      lo_q;
	logic signed [26:0] dx_q;
	logic signed [23:0] dxs_q;
	logic signed [NW-1:0] prod_q;
	logic signed [33:0] p_q;
	logic signed [47:0] r1_q;
	logic signed [37:0] r2_q;
	logic signed [35:0] ref8_q;
	logic [31:0]        coef_q;
	logic [TW-1:0]      lt_q;
	logic [31:0]        cdiff_q;
	logic signed [23:0] t_q;
	logic signed [24:0] diff_q;
	logic signed [51:0] corr_q;
	logic [31:0]        out_p_q, out_c_q;
	logic [23:0]        out_t_q;
	logic               out_f_q, out_v_q;

	logic                 div_start, div_done;
	logic signed [NW-1:0] div_num;
	logic [DW-1:0]        div_den;
	logic signed [NW:0]   div_q;

	psl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_q)
	);

	logic signed [23:0] meas_in, sup_in;
	logic signed [25:0] x_new;
	logic signed [31:0] x32;
	logic [SW-1:0]      idx, lo_new;
	logic [TW-1:0]      tidx, lt_new;
	logic signed [24:0] pdiff;
	logic signed [51:0] mulp;
	logic signed [10:0] sdiff;
	logic signed [47:0] mulr1;
	logic signed [37:0] mulr2;
	logic signed [48:0] rsum;
	logic signed [56:0] rsh;
	logic signed [NW-1:0] cnum;
	logic signed [33:0] cd;
	logic signed [11:0] tdiff;
	logic signed [45:0] mult;
	logic signed [40:0] tt;
	logic signed [23:0] t_new;
	logic signed [56:0] mulg;
	logic [NW-1:0]      gmag;
	logic [49:0]        grnd;
	logic signed [51:0] gterm;
	logic signed [52:0] asum;
	logic [52:0]        amag;
	logic signed [52:0] avg;
	logic signed [31:0] avg_sat;

	always_comb begin
		meas_in = s_tdata[23:0];
		sup_in  = s_tdata[47:24];
		x_new   = (zo_q != '0) ?
			26'(psl_pkg::ADC_PTS[0]) + 26'(meas_in) - 26'(zo_q) : 26'(meas_in);

		x32 = 32'(x_q);
		idx = '0;
		for (int i = 0; i < psl_pkg::CAL_POINTS - 1; i++) begin
			if (x32 > psl_pkg::ADC_PTS[i])
				idx = idx + SW'(1);
		end
		lo_new = (idx == '0) ? '0 : idx - SW'(1);

		pdiff = 25'(psl_pkg::PRS_PTS[lo_q + SW'(1)] - psl_pkg::PRS_PTS[lo_q]);
		mulp  = pdiff * dx_q;
		sdiff = 11'(psl_pkg::SUP_PTS[lo_q + SW'(1)] - psl_pkg::SUP_PTS[lo_q]);
		mulr1 = 24'(psl_pkg::SUP_PTS[lo_q]) * dxs_q;
		mulr2 = sdiff * dx_q;
		rsum  = 49'(r1_q) + 49'(r2_q);
		rsh   = {rsum, 8'd0};
		cnum  = {ref8_q, 22'd0};

		tidx = '0;
		for (int i = 0; i < psl_pkg::TEMP_POINTS - 1; i++) begin
			if (coef_q > 32'(psl_pkg::COEF_PTS[i]))
				tidx = tidx + TW'(1);
		end
		lt_new = (tidx == '0) ? '0 : tidx - TW'(1);
		cd     = $signed({2'b00, coef_q}) - 34'(psl_pkg::COEF_PTS[lt_new]);
		tdiff  = 12'(psl_pkg::TMP_PTS[lt_new + TW'(1)] - psl_pkg::TMP_PTS[lt_new]);
		mult   = tdiff * cd;

		tt = 41'(psl_pkg::TMP_PTS[lt_q]) + 41'(div_q);
		if (tt > 41'sd8388607)
			t_new = 24'sd8388607;
		else if (tt < -41'sd8388608)
			t_new = -24'sd8388608;
		else
			t_new = 24'(tt);

		mulg  = diff_q * gain_q;
		gmag  = prod_q[NW-1] ? NW'(-prod_q) : NW'(prod_q);
		grnd  = 50'((gmag + NW'(128)) >> 8);
		gterm = prod_q[NW-1] ? -$signed({2'b00, grnd}) : $signed({2'b00, grnd});

		asum = 53'(corr_q) + 53'(prev_q);
		amag = asum[52] ? 53'(-asum) : 53'(asum);
		amag = (amag + 53'(1)) >> 1;
		avg  = asum[52] ? -$signed(amag) : $signed(amag);
		if (avg > 53'sd2147483647)
			avg_sat = 32'sh7FFFFFFF;
		else if (avg < -53'sd2147483648)
			avg_sat = 32'sh80000000;
		else
			avg_sat = 32'(avg);
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = prod_q;
		div_den   = DW'(dxs_q);
		unique case (cmd.op)
			psl_pkg::OP_DIVP, psl_pkg::OP_DIVR: begin
				div_start = 1'b1;
			end
			psl_pkg::OP_DIVC: begin
				div_start = 1'b1;
				div_num   = sup_q[23] ? -cnum : cnum;
				// widen before negating so the most negative supply keeps its magnitude
				div_den   = sup_q[23] ? DW'(-(25'(sup_q))) : DW'(sup_q);
			end
			psl_pkg::OP_DIVT: begin
				div_start = 1'b1;
				div_den   = cdiff_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zo_q    <= '0;
			rt_q    <= psl_pkg::REF_TEMP_RESET;
			gain_q  <= '0;
			prev_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					psl_pkg::REG_ZERO_OFFSET: zo_q   <= cfg_data[23:0];
					psl_pkg::REG_REF_TEMP:    rt_q   <= cfg_data[15:0];
					psl_pkg::REG_DRIFT_GAIN:  gain_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.op == psl_pkg::OP_OUT) begin
				prev_q  <= avg_sat;
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			psl_pkg::OP_LOAD: begin
				x_q   <= x_new;
				sup_q <= sup_in;
			end
			psl_pkg::OP_SEG: begin
				lo_q  <= lo_new;
				dx_q  <= 27'(x_q) - 27'(psl_pkg::ADC_PTS[lo_new]);
				dxs_q <= 24'(psl_pkg::ADC_PTS[lo_new + SW'(1)] - psl_pkg::ADC_PTS[lo_new]);
			end
			psl_pkg::OP_MULP: prod_q <= NW'(mulp);
			psl_pkg::OP_GETP: p_q <= 34'(psl_pkg::PRS_PTS[lo_q]) + 34'(div_q);
			psl_pkg::OP_MULR: begin
				r1_q <= mulr1;
				r2_q <= mulr2;
			end
			psl_pkg::OP_SUMR: prod_q <= NW'(rsh);
			psl_pkg::OP_GETR: ref8_q <= 36'(div_q);
			psl_pkg::OP_GETC: begin
				if (sup_q == '0)
					coef_q <= '1;
				else if (div_q[NW])
					coef_q <= '0;
				else if (|div_q[NW-1:32])
					coef_q <= '1;
				else
					coef_q <= div_q[31:0];
			end
			psl_pkg::OP_SEGT: begin
				lt_q    <= lt_new;
				prod_q  <= NW'(mult);
				cdiff_q <= 32'(psl_pkg::COEF_PTS[lt_new + TW'(1)] - psl_pkg::COEF_PTS[lt_new]);
			end
			psl_pkg::OP_GETT: begin
				t_q    <= t_new;
				diff_q <= 25'(rt_q) - 25'(t_new);
			end
			psl_pkg::OP_MULG: prod_q <= NW'(mulg);
			psl_pkg::OP_CORR: corr_q <= 52'(p_q) + gterm;
			psl_pkg::OP_OUT: begin
				out_p_q <= avg_sat;
				out_c_q <= coef_q;
				out_t_q <= t_q;
				out_f_q <= (sup_q[23] || sup_q == '0);
			end
			default: begin
			end
		endcase
	end

	assign stat.div_done = div_done;
	assign stat.out_free = !out_v_q || m_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_t_q, out_c_q, out_p_q};
	assign m_tuser  = out_f_q;

endmodule

// ===== hw/rtl/psl_ctrl.sv =====
module psl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  psl_pkg::dp_stat_t stat,
	output psl_pkg::dp_cmd_t  cmd
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SEG  = 5'd1;
	localparam logic [4:0] S_MULP = 5'd2;
	localparam logic [4:0] S_DIVP = 5'd3;
	localparam logic [4:0] S_WP   = 5'd4;
	localparam logic [4:0] S_GETP = 5'd5;
	localparam logic [4:0] S_MULR = 5'd6;
	localparam logic [4:0] S_SUMR = 5'd7;
	localparam logic [4:0] S_DIVR = 5'd8;
	localparam logic [4:0] S_WR   = 5'd9;
	localparam logic [4:0] S_GETR = 5'd10;
	localparam logic [4:0] S_DIVC = 5'd11;
	localparam logic [4:0] S_WC   = 5'd12;
	localparam logic [4:0] S_GETC = 5'd13;
	localparam logic [4:0] S_SEGT = 5'd14;
	localparam logic [4:0] S_DIVT = 5'd15;
	localparam logic [4:0] S_WT   = 5'd16;
	localparam logic [4:0] S_GETT = 5'd17;
	localparam logic [4:0] S_MULG = 5'd18;
	localparam logic [4:0] S_CORR = 5'd19;
	localparam logic [4:0] S_OUT  = 5'd20;

	logic [4:0] state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.op     = psl_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op     = psl_pkg::OP_LOAD;
					state_d    = S_SEG;
				end
			end
			S_SEG:  begin cmd.op = psl_pkg::OP_SEG;  state_d = S_MULP; end
			S_MULP: begin cmd.op = psl_pkg::OP_MULP; state_d = S_DIVP; end
			S_DIVP: begin cmd.op = psl_pkg::OP_DIVP; state_d = S_WP; end
			S_WP:   if (stat.div_done) state_d = S_GETP;
			S_GETP: begin cmd.op = psl_pkg::OP_GETP; state_d = S_MULR; end
			S_MULR: begin cmd.op = psl_pkg::OP_MULR; state_d = S_SUMR; end
			S_SUMR: begin cmd.op = psl_pkg::OP_SUMR; state_d = S_DIVR; end
			S_DIVR: begin cmd.op = psl_pkg::OP_DIVR; state_d = S_WR; end
			S_WR:   if (stat.div_done) state_d = S_GETR;
			S_GETR: begin cmd.op = psl_pkg::OP_GETR; state_d = S_DIVC; end
			S_DIVC: begin cmd.op = psl_pkg::OP_DIVC; state_d = S_WC; end
			S_WC:   if (stat.div_done) state_d = S_GETC;
			S_GETC: begin cmd.op = psl_pkg::OP_GETC; state_d = S_SEGT; end
			S_SEGT: begin cmd.op = psl_pkg::OP_SEGT; state_d = S_DIVT; end
			S_DIVT: begin cmd.op = psl_pkg::OP_DIVT; state_d = S_WT; end
			S_WT:   if (stat.div_done) state_d = S_GETT;
			S_GETT: begin cmd.op = psl_pkg::OP_GETT; state_d = S_MULG; end
			S_MULG: begin cmd.op = psl_pkg::OP_MULG; state_d = S_CORR; end
			S_CORR: begin cmd.op = psl_pkg::OP_CORR; state_d = S_OUT; end
			S_OUT: begin
				// hold until the output register has room
				if (stat.out_free) begin
					cmd.op  = psl_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

// ===== hw/rtl/pressure_sensor_linearizer.sv =====
// Pressure sensor linearizer.
// Input stream s_*: one request per sample pair, accepted when s_tvalid and
// s_tready are both high. Output stream m_*: one result per request.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 zero offset, 1 reference temperature, 2 drift gain); write only while idle.
// Each result takes four rounded divisions (pressure, supply reference,
// coefficient, temperature), run one after another on the single shared
// radix-2 divider, each made of a start, 58 quotient steps and a handoff,
// with the controller's other steps in between.
// A new request is taken only once the controller is done with the last one;
// s_tready is high only while the controller is idle.
// A finished result sits in the output register; the next request is taken
// and computed meanwhile, and its result waits until m_tready frees the
// register.
// Reset (arst_n low) clears the configuration to its defaults, the previous
// pressure to zero and drops m_tvalid.
module pressure_sensor_linearizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // measure_sample[23:0], supply_sample[47:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // pressure_out[31:0], temp_coefficient[63:32],
	                               // temperature_out[87:64]
	output logic        m_tuser    // divide_fault
);
	psl_pkg::dp_cmd_t  cmd;
	psl_pkg::dp_stat_t stat;

	psl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	psl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
